// ===== sv/qled_pkg.sv =====
package qled_pkg;

  // Default saturation limit of the source byte counter
  localparam longint unsigned MaxLengthDef = 64'd65535;

  // Result groups held between the front and back ends
  localparam int unsigned QDepth = 4;

  // Most results one source byte can cause
  localparam int unsigned MaxResults = 4;

  // Characters with a special meaning in a literal
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_BAD    = 2'd2,
    KIND_NOTLIT = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_OCT  = 3'd3,
    PH_HEX4 = 3'd4,
    PH_HEX8 = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       begin_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    kind_e       kind;
    logic        char_literal;
    logic [15:0] consumed;
    logic        final_res;
  } out_item_t;

  // All results caused by one source byte: data bytes first, then an
  // optional status result
  typedef struct packed {
    logic [MaxResults-1:0][7:0] data;
    logic [2:0]                 ndata;
    logic                       has_status;
    kind_e                      status;
    logic                       char_lit;
    logic [15:0]                consumed;
  } grp_t;

endpackage

// ===== sv/quoted_literal_escape_decoder.sv =====
// Quoted literal decoder: takes one source byte per cycle while the result
// queue has room, with begin_req marking the opening quote, and delivers
// decoded text bytes, UTF-8 for octal, \u and \U escapes, followed by a
// completion, malformed or not-a-literal status. A byte is accepted
// whenever the four-entry result queue between the decoder front end and
// the output back end has room; each byte causes zero to four results, and
// the back end delivers one result per cycle while out_ready_i is high. The
// results of an accepted byte are registered in the queue and leave from
// its head. MAX_LENGTH sets where the source byte count saturates; the
// reported count saturates at 65535.
module quoted_literal_escape_decoder import qled_pkg::*; #(
  parameter longint unsigned MAX_LENGTH = MaxLengthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic push, full, q_valid, pop;
  grp_t grp_in, grp_head;

  // Byte decoder
  qled_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .full_i    (full),
    .push_o    (push),
    .grp_o     (grp_in)
  );

  // Result group queue
  qled_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .grp_i  (grp_in),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(q_valid),
    .grp_o  (grp_head)
  );

  // Result serialiser
  qled_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .grp_i      (grp_head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== sv/qled_front.sv =====
module qled_front import qled_pkg::*; #(
  parameter longint unsigned MAX_LENGTH = MaxLengthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     full_i,
  output logic     push_o,
  output grp_t     grp_o
);

  localparam int unsigned LenW = $clog2(MAX_LENGTH + 64'd1);
  localparam logic [3:0]  OctDigits  = 4'd3;
  localparam logic [3:0]  Hex4Digits = 4'd4;
  localparam logic [3:0]  Hex8Digits = 4'd8;
  localparam logic [31:0] MaxCodePoint = 32'h0010_FFFF;
  localparam logic [3:0]  CharLitMax = 4'd7;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } utf8_t;

  // Per-byte classification feeding next state, counters and results
  typedef struct packed {
    logic        start;
    logic        notlit;
    logic        bad;
    logic        drop;
    logic        emit;
    logic [31:0] cp;
    logic        lit;
    logic [7:0]  lit_val;
    logic        run_body;
    logic        go_hex4;
    logic        go_hex8;
    logic        go_oct;
    logic        oct_step;
    logic        hex_step;
  } act_t;

  function automatic utf8_t utf8_enc(input logic [31:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 32'h80) begin
      r.n    = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp < 32'h800) begin
      r.n    = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 32'h1_0000) begin
      r.n    = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.n    = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] ch);
    logic [4:0] r;
    r = '0;
    if (ch >= "0" && ch <= "9") begin
      r = {1'b1, ch[3:0]};
    end else if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")) begin
      r = {1'b1, ch[3:0] + 4'd9};
    end
    return r;
  endfunction

  phase_e          phase_q, phase_d;
  logic            sq_q, sq_d;
  logic [3:0]      dcnt_q, dcnt_d;
  logic [31:0]     acc_q, acc_d;
  logic [3:0]      cb_q, cb_d;
  logic [LenW-1:0] len_q, len_d;

  logic            in_fire;
  logic [7:0]      c;
  act_t            act;
  logic [3:0]      dcnt_inc;
  logic [31:0]     acc_oct, acc_hex;
  logic [4:0]      hx;
  utf8_t           enc;
  logic [2:0]      nd_pre, nd;
  logic [4:0]      cb_sum_pre, cb_sum;
  logic [3:0]      cb_mid;
  logic [7:0]      close_ch;
  logic            b_bad, b_done, b_esc, b_data;
  logic [LenW+15:0] len_x;
  logic [2:0]      tot;

  assign in_ready_o = !full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign c          = in_data_i.src_byte;
  assign dcnt_inc   = dcnt_q + 4'd1;
  assign acc_oct    = {acc_q[28:0], c[2:0]};
  assign hx         = hex_val(c);
  assign acc_hex    = {acc_q[27:0], hx[3:0]};

  // Classify the byte against the current phase
  always_comb begin
    act = '0;
    act.cp = acc_q;
    if (in_fire) begin
      if (in_data_i.begin_req) begin
        if (c == ChDquote || c == ChSquote) begin
          act.start = 1'b1;
        end else begin
          act.notlit = 1'b1;
        end
      end else if (phase_q != PH_IDLE) begin
        unique case (phase_q)
          PH_BODY: begin
            act.run_body = 1'b1;
          end
          PH_ESC: begin
            if (c == ChNul) begin
              act.bad = 1'b1;
            end else begin
              act.lit     = 1'b1;
              act.lit_val = c;
              unique case (c) inside
                "a": act.lit_val = 8'h07;
                "b": act.lit_val = 8'h08;
                "e": act.lit_val = 8'h1B;
                "f": act.lit_val = 8'h0C;
                "n": act.lit_val = 8'h0A;
                "r": act.lit_val = 8'h0D;
                "t": act.lit_val = 8'h09;
                "v": act.lit_val = 8'h0B;
                "u": begin
                  act.lit     = 1'b0;
                  act.go_hex4 = 1'b1;
                end
                "U": begin
                  act.lit     = 1'b0;
                  act.go_hex8 = 1'b1;
                end
                ["0":"7"]: begin
                  act.lit    = 1'b0;
                  act.go_oct = 1'b1;
                end
                default: act.lit_val = c;
              endcase
            end
          end
          PH_OCT: begin
            if (c >= "0" && c <= "7" && dcnt_q < OctDigits) begin
              act.oct_step = 1'b1;
              if (dcnt_inc >= OctDigits) begin
                act.emit = 1'b1;
                act.cp   = acc_oct;
              end
            end else begin
              // octal escape ended early: flush it, then treat byte as text
              act.emit     = 1'b1;
              act.cp       = acc_q;
              act.run_body = 1'b1;
            end
          end
          PH_HEX4, PH_HEX8: begin
            if (!hx[4]) begin
              act.bad = 1'b1;
            end else begin
              act.hex_step = 1'b1;
              if (dcnt_inc >= ((phase_q == PH_HEX4) ? Hex4Digits : Hex8Digits)) begin
                if (acc_hex > MaxCodePoint) begin
                  act.bad = 1'b1;
                end else begin
                  act.emit = 1'b1;
                  act.cp   = acc_hex;
                end
              end
            end
          end
          default: act.drop = 1'b1;
        endcase
      end
    end
  end

  // Encoded bytes ahead of any body action, and the decoded count so far
  always_comb begin
    enc        = utf8_enc(act.cp);
    nd_pre     = act.emit ? enc.n : 3'd0;
    cb_sum_pre = {1'b0, cb_q} + {2'b00, nd_pre};
    cb_mid     = (cb_sum_pre > 5'd15) ? 4'd15 : cb_sum_pre[3:0];
  end

  // Body byte: close, escape, end of text or plain data
  always_comb begin
    close_ch = sq_q ? ChSquote : ChDquote;
    b_bad    = 1'b0;
    b_done   = 1'b0;
    b_esc    = 1'b0;
    b_data   = 1'b0;
    if (act.run_body) begin
      if (c == ChNul) begin
        b_bad = 1'b1;
      end else if (c == close_ch) begin
        if (sq_q && cb_mid > CharLitMax) begin
          b_bad = 1'b1;
        end else begin
          b_done = 1'b1;
        end
      end else if (c == ChBslash) begin
        b_esc = 1'b1;
      end else begin
        b_data = 1'b1;
      end
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (act.start) begin
      phase_d = PH_BODY;
    end else if (act.notlit || act.bad || act.drop || b_bad || b_done) begin
      phase_d = PH_IDLE;
    end else if (b_esc) begin
      phase_d = PH_ESC;
    end else if (act.go_hex4) begin
      phase_d = PH_HEX4;
    end else if (act.go_hex8) begin
      phase_d = PH_HEX8;
    end else if (act.go_oct) begin
      phase_d = PH_OCT;
    end else if (act.emit || act.lit) begin
      phase_d = PH_BODY;
    end
  end

  // Counters and code accumulator
  always_comb begin
    sq_d   = sq_q;
    dcnt_d = dcnt_q;
    acc_d  = acc_q;
    len_d  = len_q;
    nd     = nd_pre + {2'b00, (b_data || act.lit)};
    cb_sum = {1'b0, cb_q} + {2'b00, nd};
    cb_d   = (cb_sum > 5'd15) ? 4'd15 : cb_sum[3:0];
    if (act.start) begin
      sq_d   = (c == ChSquote);
      len_d  = LenW'(1);
      cb_d   = '0;
      dcnt_d = '0;
      acc_d  = '0;
    end else if (in_fire && !in_data_i.begin_req && phase_q != PH_IDLE) begin
      if (len_q < LenW'(MAX_LENGTH)) begin
        len_d = len_q + LenW'(1);
      end
      if (act.go_hex4 || act.go_hex8) begin
        dcnt_d = '0;
        acc_d  = '0;
      end else if (act.go_oct) begin
        dcnt_d = 4'd1;
        acc_d  = {29'd0, c[2:0]};
      end else if (act.oct_step) begin
        dcnt_d = dcnt_inc;
        acc_d  = acc_oct;
      end else if (act.hex_step) begin
        dcnt_d = dcnt_inc;
        acc_d  = acc_hex;
      end
    end
  end

  // Result group for the queue
  always_comb begin
    grp_o          = '0;
    grp_o.char_lit = sq_q;
    grp_o.status   = KIND_DATA;
    len_x          = {16'd0, len_d};
    if (act.emit) begin
      grp_o.data = enc.b;
    end
    if (b_data || act.lit) begin
      grp_o.data[nd_pre[1:0]] = act.lit ? act.lit_val : c;
    end
    grp_o.ndata = nd;
    if (act.notlit) begin
      grp_o.has_status = 1'b1;
      grp_o.status     = KIND_NOTLIT;
      grp_o.char_lit   = 1'b0;
    end else if (act.bad || b_bad) begin
      grp_o.has_status = 1'b1;
      grp_o.status     = KIND_BAD;
    end else if (b_done) begin
      grp_o.has_status = 1'b1;
      grp_o.status     = KIND_DONE;
      grp_o.consumed   = (len_x > (LenW + 16)'(16'hFFFF)) ? 16'hFFFF : len_x[15:0];
    end
    tot    = grp_o.ndata + {2'b00, grp_o.has_status};
    push_o = (tot != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      sq_q    <= 1'b0;
      dcnt_q  <= '0;
      acc_q   <= '0;
      cb_q    <= '0;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sq_q    <= sq_d;
      dcnt_q  <= dcnt_d;
      acc_q   <= acc_d;
      cb_q    <= cb_d;
      len_q   <= len_d;
    end
  end

  // A group never holds more results than the back end can index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (tot <= 3'(MaxResults)))
    else $error("result group too large");

  // Any status result closes the literal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && grp_o.has_status) |=> (phase_q == PH_IDLE))
    else $error("status issued but literal still open");

  // Groups only come from accepted bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> in_fire)
    else $error("group pushed without a transaction");

endmodule

// ===== sv/qled_fifo.sv =====
module qled_fifo import qled_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  grp_t grp_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output grp_t grp_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  grp_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign grp_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and occupancy update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Group storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= grp_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("queue occupancy out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("group pushed into a full queue");

endmodule

// ===== sv/qled_back.sv =====
module qled_back import qled_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  grp_t      grp_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned PosW = $clog2(MaxResults);

  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      tot;
  logic            is_data, last, out_fire;

  assign tot         = grp_i.ndata + {2'b00, grp_i.has_status};
  assign is_data     = ({1'b0, pos_q} < grp_i.ndata);
  assign last        = ({1'b0, pos_q} == tot - 3'd1);
  assign out_valid_o = valid_i;
  assign out_fire    = out_valid_o && out_ready_i;
  assign pop_o       = out_fire && last;

  // Current result of the head group
  always_comb begin
    out_data_o              = '0;
    out_data_o.char_literal = grp_i.char_lit;
    out_data_o.final_res    = last;
    if (is_data) begin
      out_data_o.kind     = KIND_DATA;
      out_data_o.out_byte = grp_i.data[pos_q];
    end else begin
      out_data_o.kind     = grp_i.status;
      out_data_o.consumed = grp_i.consumed;
    end
  end

  // Step through the group, one result per transaction
  always_comb begin
    pos_d = pos_q;
    if (out_fire) begin
      pos_d = last ? '0 : pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ({1'b0, pos_q} < tot))
    else $error("result index beyond group");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import qled_pkg::*;

  // Run limit in clock cycles
  localparam int unsigned CycleLimit = 1000000;
  // Cycles allowed after the last expected result has arrived
  localparam int unsigned TailCycles = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // Traffic shaping, in percent per cycle
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  // Receiver hold-off, counted down by the receiver process
  int unsigned rx_hold_cycles = 0;

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;

  // Escape letters with a fixed meaning
  string simple_escapes = "abefnrtv\\'\"";

  // Decoder state as predicted
  phase_e      lit_phase = PH_IDLE;
  logic        lit_single = 1'b0;
  int unsigned lit_digits = 0;
  logic [31:0] lit_code = '0;
  int unsigned lit_chars = 0;
  logic [31:0] lit_length = '0;

  // Results of the byte being decoded, and results still to arrive
  out_item_t byte_results[$];
  out_item_t decoded_results[$];

  quoted_literal_escape_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 12 ns clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    while (cycle_count <= CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------

  function automatic void put_result(logic [7:0] b, kind_e k, logic [15:0] cons);
    out_item_t r;
    if (byte_results.size() >= MaxResults) return;
    r.out_byte     = b;
    r.kind         = k;
    r.char_literal = (k == KIND_NOTLIT) ? 1'b0 : lit_single;
    r.consumed     = cons;
    r.final_res    = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void emit_text(logic [7:0] b);
    put_result(b, KIND_DATA, 16'h0000);
    if (lit_chars < 15) lit_chars++;
  endfunction

  function automatic void fail_literal();
    put_result(8'h00, KIND_BAD, 16'h0000);
    lit_phase = PH_IDLE;
  endfunction

  function automatic void emit_utf8(logic [31:0] cp);
    if (cp < 32'h80) begin
      emit_text(cp[7:0]);
    end else if (cp < 32'h800) begin
      emit_text({3'b110, cp[10:6]});
      emit_text({2'b10, cp[5:0]});
    end else if (cp < 32'h10000) begin
      emit_text({4'b1110, cp[15:12]});
      emit_text({2'b10, cp[11:6]});
      emit_text({2'b10, cp[5:0]});
    end else begin
      emit_text({5'b11110, cp[20:18]});
      emit_text({2'b10, cp[17:12]});
      emit_text({2'b10, cp[11:6]});
      emit_text({2'b10, cp[5:0]});
    end
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void body_char(logic [7:0] c);
    logic [7:0] close_ch;
    close_ch = lit_single ? ChSquote : ChDquote;
    if (c == ChNul) begin
      fail_literal();
    end else if (c == close_ch) begin
      // char literals longer than seven decoded bytes are rejected here
      if (lit_single && lit_chars > 7) begin
        fail_literal();
      end else begin
        put_result(8'h00, KIND_DONE,
                   (lit_length > 32'hFFFF) ? 16'hFFFF : lit_length[15:0]);
        lit_phase = PH_IDLE;
      end
    end else if (c == ChBslash) begin
      lit_phase = PH_ESC;
    end else begin
      emit_text(c);
    end
  endfunction

  function automatic void escape_char(logic [7:0] c);
    logic [7:0] v;
    if (c == ChNul) begin
      fail_literal();
      return;
    end
    lit_phase = PH_BODY;
    v = c;
    case (c)
      "a": v = 8'h07;
      "b": v = 8'h08;
      "e": v = 8'h1B;
      "f": v = 8'h0C;
      "n": v = 8'h0A;
      "r": v = 8'h0D;
      "t": v = 8'h09;
      "v": v = 8'h0B;
      "u", "U": begin
        lit_phase  = (c == "u") ? PH_HEX4 : PH_HEX8;
        lit_digits = 0;
        lit_code   = '0;
        return;
      end
      default: begin
        if (c >= "0" && c <= "7") begin
          lit_phase  = PH_OCT;
          lit_digits = 1;
          lit_code   = {29'd0, c[2:0]};
          return;
        end
      end
    endcase
    // unknown escapes give the byte itself
    emit_text(v);
  endfunction

  // Expected results of one accepted source byte
  function automatic void decode_source_byte(in_item_t item);
    logic [7:0]  c;
    int          hv;
    int unsigned want;
    c = item.src_byte;
    byte_results.delete();
    if (item.begin_req) begin
      if (c == ChDquote || c == ChSquote) begin
        lit_single = (c == ChSquote);
        lit_length = 1;
        lit_chars  = 0;
        lit_digits = 0;
        lit_code   = '0;
        lit_phase  = PH_BODY;
      end else begin
        put_result(8'h00, KIND_NOTLIT, 16'h0000);
        lit_phase = PH_IDLE;
      end
    end else if (lit_phase != PH_IDLE) begin
      if (lit_length < MaxLengthDef) lit_length++;
      case (lit_phase)
        PH_BODY: body_char(c);
        PH_ESC:  escape_char(c);
        PH_OCT: begin
          if (c >= "0" && c <= "7" && lit_digits < 3) begin
            lit_code = {lit_code[28:0], c[2:0]};
            lit_digits++;
            if (lit_digits >= 3) begin
              emit_utf8(lit_code);
              lit_phase = PH_BODY;
            end
          end else begin
            // a non-octal byte ends the escape and is then read as text
            emit_utf8(lit_code);
            lit_phase = PH_BODY;
            body_char(c);
          end
        end
        PH_HEX4, PH_HEX8: begin
          hv   = hex_value(c);
          want = (lit_phase == PH_HEX4) ? 4 : 8;
          if (hv < 0) begin
            fail_literal();
          end else begin
            lit_code = {lit_code[27:0], 4'(hv)};
            lit_digits++;
            if (lit_digits >= want) begin
              if (lit_code > 32'h10FFFF) begin
                fail_literal();
              end else begin
                emit_utf8(lit_code);
                lit_phase = PH_BODY;
              end
            end
          end
        end
        default: lit_phase = PH_IDLE;
      endcase
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].final_res = 1'b1;
    foreach (byte_results[i]) decoded_results.push_back(byte_results[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Receiver: long hold-off when asked, random stalls otherwise
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic void report_field(string fld, logic [15:0] want, logic [15:0] got);
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fld, want, got);
    mismatch_count++;
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (decoded_results.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, got %p", $time, got);
      mismatch_count++;
      return;
    end
    want = decoded_results.pop_front();
    if (got.out_byte !== want.out_byte)
      report_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
    if (got.kind !== want.kind)
      report_field("kind", 16'(want.kind), 16'(got.kind));
    if (got.char_literal !== want.char_literal)
      report_field("char_literal", 16'(want.char_literal), 16'(got.char_literal));
    if (got.consumed !== want.consumed)
      report_field("consumed", want.consumed, got.consumed);
    if (got.final_res !== want.final_res)
      report_field("final_res", 16'(want.final_res), 16'(got.final_res));
  endfunction

  // Outputs are sampled mid-cycle; the transaction completes at the next edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_result(out_data_o);
    end
  end

  // ---------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------

  // One source byte transaction, with random idle cycles ahead of it
  task automatic send_item(input logic [7:0] b, input logic beg);
    in_item_t item;
    logic     ready_seen;
    item.src_byte  = b;
    item.begin_req = beg;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(negedge clk_i);
      ready_seen = in_ready_o;
      @(posedge clk_i);
    end while (!ready_seen);
    bytes_sent++;
    decode_source_byte(item);
  endtask

  // Sends a text; the first byte opens a literal when asked
  task automatic send_text(input string s, input logic opens);
    for (int i = 0; i < s.len(); i++) send_item(s[i], opens && (i == 0));
  endtask

  // Stops sending until every expected result has come
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decoded_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 10) return 8'h30 + 8'(v);
    return (($urandom_range(1) == 0) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  task automatic send_hex(input logic [31:0] cp, input int ndig);
    for (int k = ndig - 1; k >= 0; k--) send_item(hex_char(cp[4*k +: 4]), 1'b0);
  endtask

  // One random element of a literal body
  task automatic send_random_piece(input logic [7:0] close_ch);
    logic [7:0]  b;
    logic [31:0] cp;
    int unsigned ndig;
    case ($urandom_range(9))
      0, 1, 2: begin
        do begin
          b = 8'($urandom_range(1, 255));
        end while (b == close_ch || b == ChBslash);
        send_item(b, 1'b0);
      end
      3: begin
        send_item(ChBslash, 1'b0);
        send_item(simple_escapes[$urandom_range(simple_escapes.len() - 1)], 1'b0);
      end
      4: begin
        do begin
          b = 8'($urandom_range(1, 255));
        end while (b == "u" || b == "U" || (b >= "0" && b <= "7"));
        send_item(ChBslash, 1'b0);
        send_item(b, 1'b0);
      end
      5, 6: begin
        ndig = $urandom_range(1, 3);
        send_item(ChBslash, 1'b0);
        repeat (ndig) send_item(8'h30 + 8'($urandom_range(7)), 1'b0);
      end
      7: begin
        case ($urandom_range(2))
          0:       cp = $urandom_range(32'h7F);
          1:       cp = $urandom_range(32'h7FF);
          default: cp = $urandom_range(32'hFFFF);
        endcase
        send_item(ChBslash, 1'b0);
        send_item("u", 1'b0);
        send_hex(cp, 4);
      end
      8: begin
        case ($urandom_range(4))
          0:       cp = $urandom_range(32'h7F);
          1:       cp = $urandom_range(32'h7FF);
          2:       cp = $urandom_range(32'hFFFF);
          3:       cp = $urandom_range(32'h10FFFF);
          default: cp = ($urandom_range(1) == 0) ? $urandom : 32'h0011_0000;
        endcase
        send_item(ChBslash, 1'b0);
        send_item("U", 1'b0);
        send_hex(cp, 8);
      end
      default: send_item(8'($urandom_range(255)), 1'b0);
    endcase
  endtask

  // A literal with random content; most close properly
  task automatic send_random_literal();
    logic        single;
    logic [7:0]  close_ch;
    int unsigned nparts;
    single   = ($urandom_range(2) == 0);
    close_ch = single ? ChSquote : ChDquote;
    nparts   = single ? $urandom_range(10) : $urandom_range(12);
    send_item(close_ch, 1'b1);
    repeat (nparts) send_random_piece(close_ch);
    case ($urandom_range(19))
      0: send_item(ChNul, 1'b0);
      1: ;  // left open, the next opening abandons it
      2: send_text("\\uz", 1'b0);
      default: send_item(close_ch, 1'b0);
    endcase
  endtask

  // Stray bytes, some of them claiming to open a literal
  task automatic send_noise();
    int unsigned cnt;
    cnt = $urandom_range(1, 3);
    repeat (cnt) send_item(8'($urandom_range(255)), ($urandom_range(3) == 0));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic apply_reset();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  endtask

  // Opening, not-a-literal, ignored bytes and abandoned literals
  task automatic test_framing();
    send_item(8'hFF, 1'b1);
    send_item(ChNul, 1'b0);
    send_text("'ab", 1'b1);
    send_text("\"x\"", 1'b1);
    send_text("\"\"", 1'b1);
  endtask

  // Simple, unknown and octal escapes, and an escaped quote
  task automatic test_escapes();
    send_text("\"\\a\\b\\e\\f\\n\\r\\t\\v\\\\\\'\"", 1'b1);
    send_text("\"\\9\\12x\\uD800\\\"\"", 1'b1);
  endtask

  // Multi-byte encodings, the largest code point and bad hex digits
  task automatic test_code_points();
    send_text("\"\\777\\U0010FFFF\\u07ff\"", 1'b1);
    send_text("'\\U00110000", 1'b1);
    send_text("\"\\uAbg", 1'b1);
  endtask

  // Text ending inside a literal, and char literal length
  task automatic test_malformed();
    send_text("\"ok", 1'b1);
    send_item(ChNul, 1'b0);
    send_text("\"\\1", 1'b1);
    send_item(ChNul, 1'b0);
    send_text("'abcdefg'", 1'b1);
    send_text("'abcdefgh'", 1'b1);
  endtask

  // Receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    drain_results();
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = 200;
    send_text("\"\\U0001F600\\U0001F600hold on\\u20AC\"", 1'b1);
    drain_results();
  endtask

  // Random literals under each traffic pattern
  task automatic test_random();
    int unsigned start_count;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
        default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
      endcase
      start_count = bytes_sent;
      while (bytes_sent - start_count < 32) begin
        if ($urandom_range(9) == 0) send_noise();
        else send_random_literal();
      end
      drain_results();
    end
  endtask

  initial begin
    apply_reset();
    test_framing();
    test_escapes();
    test_code_points();
    test_malformed();
    test_backpressure();
    test_random();
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/qled_pkg.sv
sv/qled_front.sv
sv/qled_fifo.sv
sv/qled_back.sv
sv/quoted_literal_escape_decoder.sv
verif/testbench.sv
